FILE: hw/rtl/mfwa_pkg.sv
`timescale 1ns / 1ps

package mfwa_pkg;

  localparam int WINDOW_DEFAULT = 5;
  localparam int SAMPLE_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_CAND,
    S_CLOAD,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

FILE: hw/rtl/median_filter_warmup_average.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// -------   --------------------------   ----------------------------------
// sample    sample_valid, sample_stall   sample[15:0]
// result    result_valid, result_stall   filtered[15:0], window_full
//
// A sample is written into the window memory in the cycle it is accepted.
// Warm-up mean: memory reads of the samples written so far, then the bit-serial
// divider, then a load of the result register.
// Median: each candidate is loaded and then compared with every sample on the single
// read port, up to WINDOW candidates per sample.
// Reset clears the write position, the full flag and the result valid flag, and
// stalls the input; the window memory is not cleared. A waiting result does not
// block the next sample.

module median_filter_warmup_average
  import mfwa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [SAMPLE_W-1:0] filtered,
  output logic                window_full
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = SAMPLE_W + CW;
  localparam int BW = $clog2(SW + 1);
  localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);
  localparam logic [CW:0] KC = (CW + 1)'(WINDOW / 2);
  localparam logic [BW-1:0] DIV_LAST = BW'(SW - 1);

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rdata;
  logic [IW-1:0]       raddr;

  state_t state, state_next;

  logic [IW-1:0]       wpos;
  logic                filled;
  logic [CW-1:0]       cnt;
  logic [IW-1:0]       addr;
  logic                issuing;
  logic                pend;
  logic                pend_last;
  logic [SW-1:0]       acc;
  logic [CW-1:0]       rem;
  logic [BW-1:0]       bcnt;
  logic [IW-1:0]       cand_idx;
  logic [SAMPLE_W-1:0] cand;
  logic [CW-1:0]       lt;
  logic [CW-1:0]       eq;
  logic [SAMPLE_W-1:0] res;

  logic                accept;
  logic                out_free;
  logic [IW-1:0]       scan_last;
  logic [CW-1:0]       lt_new;
  logic [CW-1:0]       eq_new;
  logic [CW:0]         rank_hi;
  logic                match;
  logic [CW:0]         trial;
  logic                ge;
  logic [CW:0]         diff;
  logic [SW-1:0]       quo_next;

  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    scan_last = (state == S_SUM) ? IW'(cnt - CW'(1)) : LAST;
    lt_new    = lt + CW'(rdata < cand);
    eq_new    = eq + CW'(rdata == cand);
    rank_hi   = {1'b0, lt_new} + {1'b0, eq_new};
    match     = ({1'b0, lt_new} <= KC) && (rank_hi > KC);
    trial     = {rem, acc[SW-1]};
    ge        = trial >= {1'b0, cnt};
    diff      = trial - {1'b0, cnt};
    quo_next  = {acc[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wpos] <= sample;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = rst || (state != S_IDLE);
    raddr        = addr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (filled || (wpos == LAST)) ? S_CAND : S_SUM;
        end
      end
      S_SUM: begin
        if (pend && pend_last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (bcnt == DIV_LAST) begin
          state_next = S_OUT;
        end
      end
      S_CAND: begin
        raddr      = cand_idx;
        state_next = S_CLOAD;
      end
      S_CLOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (pend && pend_last) begin
          state_next = match ? S_OUT : S_CAND;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos         <= '0;
      filled       <= 1'b0;
      result_valid <= 1'b0;
      issuing      <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            wpos     <= (wpos == LAST) ? '0 : wpos + IW'(1);
            filled   <= filled || (wpos == LAST);
            cnt      <= CW'(wpos) + CW'(1);
            acc      <= '0;
            addr     <= '0;
            issuing  <= 1'b1;
            pend     <= 1'b0;
            cand_idx <= '0;
          end
        end
        S_SUM: begin
          if (pend) begin
            acc <= acc + SW'(rdata);
          end
          if (pend && pend_last) begin
            bcnt <= '0;
            rem  <= '0;
          end
        end
        S_DIV: begin
          acc  <= quo_next;
          rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
          bcnt <= bcnt + BW'(1);
          if (bcnt == DIV_LAST) begin
            res <= quo_next[SAMPLE_W-1:0];
          end
        end
        S_CAND: begin
          addr    <= '0;
          issuing <= 1'b1;
          pend    <= 1'b0;
          lt      <= '0;
          eq      <= '0;
        end
        S_CLOAD: begin
          cand <= rdata;
        end
        S_SCAN: begin
          if (pend) begin
            lt <= lt_new;
            eq <= eq_new;
          end
          if (pend && pend_last) begin
            if (match) begin
              res <= cand;
            end else begin
              cand_idx <= cand_idx + IW'(1);
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            filtered     <= res;
            window_full  <= filled;
            result_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if ((state == S_SUM) || (state == S_CLOAD) || (state == S_SCAN)) begin
        if (issuing) begin
          pend      <= 1'b1;
          pend_last <= (addr == scan_last);
          if (addr == scan_last) begin
            issuing <= 1'b0;
          end else begin
            addr <= addr + IW'(1);
          end
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

  a_wpos_range: assert property (@(posedge clk) disable iff (rst) wpos <= LAST)
    else $error("write position beyond the window");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output state");

  a_mean_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM || state == S_DIV) |-> (cnt != '0 && !filled))
    else $error("mean taken with an empty count or a full window");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < cnt))
    else $error("divider remainder not below the count");

  a_scan_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (({1'b0, lt} + {1'b0, eq}) <= (CW + 1)'(WINDOW)))
    else $error("rank counts exceed the window size");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mfwa_pkg::*;

  localparam int WIN = WINDOW_DEFAULT;
  localparam int DRAIN_CYCLES = WIN * (WIN + 2) + 40;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                window_full;
  } filter_out_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                result_stall = 1'b0;
  logic                sample_stall;
  logic                result_valid;
  logic [SAMPLE_W-1:0] filtered;
  logic                window_full;

  logic [SAMPLE_W-1:0] window_copy [WIN];
  int unsigned         next_slot = 0;
  bit                  have_wrapped = 1'b0;
  filter_out_t         awaited_results [$];
  logic [SAMPLE_W-1:0] last_sample = '0;

  int                  mismatches = 0;
  int unsigned         cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  logic                hold_active = 1'b0;

  median_filter_warmup_average #(
    .WINDOW(WIN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .filtered(filtered),
    .window_full(window_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  // Writes one sample into the window copy and returns the filter output it causes.
  function automatic filter_out_t apply_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] sorted [WIN];
    logic [SAMPLE_W-1:0] key;
    logic [20:0]         sum;
    filter_out_t         r;
    int                  i;
    int                  j;
    window_copy[next_slot] = s;
    next_slot++;
    if (next_slot == WIN) begin
      next_slot = 0;
      have_wrapped = 1'b1;
    end
    if (have_wrapped) begin
      sorted = window_copy;
      for (i = 1; i < WIN; i++) begin
        key = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      r.filtered = sorted[WIN/2];
    end else begin
      sum = '0;
      for (i = 0; i < next_slot; i++) begin
        sum += window_copy[i];
      end
      r.filtered = SAMPLE_W'(sum / next_slot);
    end
    r.window_full = have_wrapped;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(4))
      0, 1: return SAMPLE_W'($urandom);
      2: return SAMPLE_W'($urandom_range(7));
      3: return SAMPLE_W'(16'hFFFF - $urandom_range(7));
      default: return SAMPLE_W'(last_sample + $urandom_range(2) - 1);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    awaited_results.push_back(apply_sample(s));
    last_sample = s;
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    filter_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transaction: filtered=%0d window_full=%0b",
                   filtered, window_full);
        end
      end else begin
        want = awaited_results.pop_front();
        if (filtered !== want.filtered || window_full !== want.window_full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected filtered=%0d window_full=%0b, got %0d %0b",
                     want.filtered, want.window_full, filtered, window_full);
          end
        end
      end
    end
  end

  // The only warm-up of the run: large sums, truncated means, then the first median.
  task automatic test_warmup_mean();
    send_idle_pct = 0;
    stall_pct = 0;
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    drain_results();
  endtask

  task automatic test_window_corners();
    send_idle_pct = 20;
    stall_pct = 30;
    repeat (WIN) send_sample(16'h0000);
    repeat (WIN) send_sample(16'hFFFF);
    for (int k = 0; k < WIN; k++) begin
      send_sample((k % 2) ? 16'hAAAA : 16'h5555);
    end
    send_sample(16'd3);
    send_sample(16'd1);
    send_sample(16'd4);
    send_sample(16'd1);
    send_sample(16'd5);
    send_sample(16'd9);
    send_sample(16'd7);
    send_sample(16'd7);
    send_sample(16'd2);
    send_sample(16'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int count);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (count) send_sample(pick_sample());
    drain_results();
  endtask

  // A long output hold while samples keep coming, so the block backs up its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    repeat (40) send_sample(pick_sample());
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_warmup_mean();
    test_window_corners();
    test_random_traffic(0, 0, 130);
    test_random_traffic(70, 0, 130);
    test_random_traffic(0, 70, 130);
    test_random_traffic(16, 16, 130);
    test_output_backpressure();
    if (awaited_results.size() != 0) begin
      $display("%0d expected results never arrived.", awaited_results.size());
    end
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mfwa_pkg.sv
hw/rtl/median_filter_warmup_average.sv
verif/tb.sv
